/* sv/lzwu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lzwu_pkg;

  // Default dictionary size
  localparam int DICT_ENTRIES_DEF = 4096;

  // Single-byte alphabet, byte width, omega group limit
  localparam int ALPHABET     = 256;
  localparam int BYTE_W       = 8;
  localparam int OMEGA_GROUPS = 8;

  // Register map
  localparam int          REG_AW        = 3;
  localparam logic        ADDR_CODE_KIND = 1'b0;  // paddr[2] of code_kind

  // Code kinds
  localparam logic [1:0] KIND_OMEGA = 2'd0;
  localparam logic [1:0] KIND_DELTA = 2'd1;
  localparam logic [1:0] KIND_GAMMA = 2'd2;
  localparam logic [1:0] KIND_FIB   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FC,
    ST_ENT,
    ST_BEGIN,
    ST_OM_BUILD,
    ST_OM_EMIT,
    ST_G_ZERO,
    ST_G_VAL,
    ST_D_ZERO,
    ST_D_N,
    ST_D_V,
    ST_F_CALC,
    ST_F_EMIT,
    ST_F_ONE,
    ST_FIN,
    ST_PAD,
    ST_FLUSH
  } state_t;

  // Number of Fibonacci terms (1, 2, 3, 5, ...) not above limit
  function automatic int fib_count(input int limit);
    int a;
    int b;
    int t;
    int n;
    a = 1;
    b = 2;
    n = 0;
    while (a <= limit) begin
      n++;
      t = a + b;
      a = b;
      b = t;
    end
    return n;
  endfunction

  // Fibonacci term i of the sequence 1, 2, 3, 5, ...
  function automatic int fib_at(input int i);
    int a;
    int b;
    int t;
    a = 1;
    b = 2;
    for (int j = 0; j < i; j++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Position of the highest set bit plus one
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* sv/lzwu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lzwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/lzw_universal_code_encoder_unit.sv */
// Flow: a byte that extends a known phrase reads its first child, then visits each further
//   sibling in the dictionary trie; a miss adds the serial code (up to ~25 code bits, sent
//   bit by bit and stalled by output back-pressure), its setup and the byte flush.
// Throughput: one input byte at a time; the trie walk and the serial code set the pace.
// Reset (synchronous, rst high) clears control state; the RAMs need no clearing, as a
//   link is trusted only below the fill count and with a matching prefix.
`timescale 1ns / 1ps
`default_nettype none

module lzw_universal_code_encoder_unit #(
  parameter int DICT_ENTRIES = lzwu_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lzwu_pkg::REG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // input bytes
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       stream_end,
  // packed output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [7:0]                 packed_byte,
  output logic                            run_last,
  output logic                            stream_done
);

  import lzwu_pkg::*;

  localparam int CW  = $clog2(DICT_ENTRIES);
  localparam int VW  = CW + 1;
  localparam int LW  = $clog2(VW + 1);
  localparam int FN  = fib_count(DICT_ENTRIES);
  localparam int FIW = (FN > 1) ? $clog2(FN) : 1;
  localparam int SW  = (VW > FN) ? VW : FN;
  localparam int SLW = $clog2(SW + 1);
  localparam int EW  = 2 * CW + BYTE_W;
  localparam int KW  = $clog2(OMEGA_GROUPS + 1);
  localparam int GIW = $clog2(OMEGA_GROUPS);

  state_t state, state_next;

  logic [1:0]        code_kind;
  logic [CW:0]       next_code;
  logic [CW-1:0]     cur;
  logic              phrase_open;
  logic [6:0]        acc;
  logic [2:0]        cnt;
  logic [7:0]        item_b;
  logic              item_last;
  logic              final_sent;
  logic [CW-1:0]     cand;
  logic              from_head;
  logic [CW-1:0]     head;
  logic [VW-1:0]     cv;
  logic [LW-1:0]     nreg;
  logic [VW-1:0]     og;
  logic [VW-1:0]     grp [OMEGA_GROUPS];
  logic [KW-1:0]     k;
  logic [VW-1:0]     fv;
  logic [FIW-1:0]    fidx;
  logic [FN-1:0]     fword;
  logic [FIW-1:0]    ftop;
  logic              ftop_set;
  logic [SW-1:0]     seg_val;
  logic [SLW-1:0]    seg_len;
  logic              seg_lsb;
  logic [7:0]        hold_byte;
  logic              hold_done;
  logic              hold_valid;

  // Fibonacci terms as a constant table
  logic [VW-1:0] fib_tab [FN];
  for (genvar i = 0; i < FN; i++) begin : g_fib
    assign fib_tab[i] = VW'(fib_at(i));
  end

  // RAM ports
  logic [CW-1:0] fc_rdata;
  logic [EW-1:0] ent_rdata;
  logic [CW-1:0] ent_raddr;
  logic          ins_we;

  logic [CW-1:0] e_prefix;
  logic [7:0]    e_byte;
  logic [CW-1:0] e_sib;
  logic          fc_ok, ent_ok, ent_hit, ent_more, miss, room;
  logic [CW-1:0] head_val;

  // Segment loader
  logic           seg_free, seg_load, ld_lsb;
  logic [SW-1:0]  ld_val;
  logic [SLW-1:0] ld_len;

  // Bit packer
  logic out_free, emit_stall, bit_fire, bit_val, out_load;
  logic [7:0] pad_byte;
  logic [KW-1:0] k_dec;
  logic [VW-1:0] grp_top;
  logic [LW-1:0] m_len;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_CODE_KIND) ? {30'd0, code_kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_kind <= KIND_OMEGA;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_CODE_KIND) begin
      code_kind <= pwdata[1:0];
    end
  end

  // Dictionary trie: first child per code, and {prefix, byte, next sibling} per code
  lzwu_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_fc_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (cur),
    .wdata (next_code[CW-1:0]),
    .raddr (cur),
    .rdata (fc_rdata)
  );

  lzwu_ram #(.WIDTH(EW), .DEPTH(DICT_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (next_code[CW-1:0]),
    .wdata ({cur, item_b, head_val}),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign e_prefix = ent_rdata[EW-1:CW+BYTE_W];
  assign e_byte   = ent_rdata[CW+BYTE_W-1:CW];
  assign e_sib    = ent_rdata[CW-1:0];

  // Lookup decisions
  assign fc_ok    = ({1'b0, fc_rdata} >= (CW+1)'(ALPHABET)) && ({1'b0, fc_rdata} < next_code);
  assign ent_ok   = !from_head || (e_prefix == cur);
  assign ent_hit  = ent_ok && (e_byte == item_b);
  assign ent_more = ent_ok && (e_sib != '0);
  assign room     = next_code < (CW+1)'(DICT_ENTRIES);
  assign miss     = (state == ST_FC && !fc_ok) ||
                    (state == ST_ENT && !ent_hit && !ent_more);
  assign ins_we   = miss && room;
  assign ent_raddr = (state == ST_FC) ? fc_rdata : e_sib;

  always_comb begin
    if (state == ST_FC) head_val = '0;
    else if (from_head) head_val = ent_ok ? cand : '0;
    else head_val = head;
  end

  // Packer handshake
  assign seg_free   = (seg_len == '0);
  assign out_free   = !out_valid || out_ready;
  assign emit_stall = (cnt == 3'd7) && hold_valid && !out_free;
  assign bit_fire   = !seg_free && !emit_stall;
  assign bit_val    = seg_lsb ? seg_val[0] : seg_val[SW-1];
  assign pad_byte   = 8'({acc, 1'b0} << (3'd7 - cnt));
  // held byte moves to the output register
  assign out_load   = hold_valid && out_free &&
                      ((bit_fire && cnt == 3'd7) || state == ST_PAD || state == ST_FLUSH);

  assign k_dec   = k - 1'b1;
  assign grp_top = grp[k_dec[GIW-1:0]];
  assign m_len   = LW'(bit_len(32'(nreg)));

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and segment loads
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    seg_load   = 1'b0;
    ld_val     = '0;
    ld_len     = '0;
    ld_lsb     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!phrase_open) state_next = stream_end ? ST_BEGIN : ST_IDLE;
          else state_next = ST_FC;
        end
      end
      ST_FC: begin
        state_next = fc_ok ? ST_ENT : ST_BEGIN;
      end
      ST_ENT: begin
        priority if (ent_hit) state_next = item_last ? ST_BEGIN : ST_IDLE;
        else if (ent_more) state_next = ST_ENT;
        else state_next = ST_BEGIN;
      end
      ST_BEGIN: begin
        unique case (code_kind)
          KIND_OMEGA: state_next = ST_OM_BUILD;
          KIND_DELTA: state_next = ST_D_ZERO;
          KIND_GAMMA: state_next = ST_G_ZERO;
          default:    state_next = ST_F_CALC;
        endcase
      end
      ST_OM_BUILD: begin
        if (og <= VW'(1)) state_next = ST_OM_EMIT;
      end
      ST_OM_EMIT: begin
        if (seg_free) begin
          seg_load = 1'b1;
          if (k != '0) begin
            ld_val = SW'(grp_top);
            ld_len = SLW'(bit_len(32'(grp_top)));
          end else begin
            ld_len = SLW'(1);
            state_next = ST_FIN;
          end
        end
      end
      ST_G_ZERO: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_len = SLW'(nreg) - 1'b1;
          state_next = ST_G_VAL;
        end
      end
      ST_G_VAL: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_val = SW'(cv);
          ld_len = SLW'(nreg);
          state_next = ST_FIN;
        end
      end
      ST_D_ZERO: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_len = SLW'(m_len) - 1'b1;
          state_next = ST_D_N;
        end
      end
      ST_D_N: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_val = SW'(nreg);
          ld_len = SLW'(m_len);
          state_next = ST_D_V;
        end
      end
      ST_D_V: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_val = SW'(cv);
          ld_len = SLW'(nreg) - 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_F_CALC: begin
        if (fidx == '0) state_next = ST_F_EMIT;
      end
      ST_F_EMIT: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_val = SW'(fword);
          ld_len = SLW'(ftop) + 1'b1;
          ld_lsb = 1'b1;
          state_next = ST_F_ONE;
        end
      end
      ST_F_ONE: begin
        if (seg_free) begin
          seg_load = 1'b1;
          ld_val = SW'(1);
          ld_len = SLW'(1);
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (seg_free) begin
          priority if (item_last && !final_sent) state_next = ST_BEGIN;
          else if (item_last) state_next = ST_PAD;
          else state_next = ST_FLUSH;
        end
      end
      ST_PAD: begin
        if (!hold_valid || out_free) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!hold_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Phrase and dictionary control
  always_ff @(posedge clk) begin
    if (rst) begin
      next_code   <= (CW+1)'(ALPHABET);
      phrase_open <= 1'b0;
      cur         <= '0;
      final_sent  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_b    <= data_byte;
            item_last <= stream_end;
            if (!phrase_open) begin
              cur         <= CW'(data_byte);
              phrase_open <= 1'b1;
              final_sent  <= 1'b1;
              cv          <= VW'(data_byte) + 1'b1;
            end else begin
              final_sent <= 1'b0;
            end
          end
        end
        ST_FC: begin
          cand      <= fc_rdata;
          from_head <= 1'b1;
        end
        ST_ENT: begin
          if (from_head) head <= ent_ok ? cand : '0;
          if (ent_hit) begin
            cur <= cand;
            if (item_last) begin
              cv         <= VW'(cand) + 1'b1;
              final_sent <= 1'b1;
            end
          end else if (ent_more) begin
            cand      <= e_sib;
            from_head <= 1'b0;
          end
        end
        ST_FIN: begin
          if (seg_free && item_last && !final_sent) begin
            final_sent <= 1'b1;
            cv         <= VW'(cur) + 1'b1;
          end
        end
        ST_PAD: begin
          if (!hold_valid || out_free) begin
            next_code   <= (CW+1)'(ALPHABET);
            phrase_open <= 1'b0;
            cur         <= '0;
          end
        end
        default: ;
      endcase
      // A miss sends the old phrase and restarts from the byte
      if (miss) begin
        cv  <= VW'(cur) + 1'b1;
        cur <= CW'(item_b);
        if (room) next_code <= next_code + 1'b1;
      end
    end
  end

  // Code setup: bit length, omega groups, Fibonacci digits
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      ftop_set <= 1'b0;
    end else begin
      unique case (state)
        ST_BEGIN: begin
          nreg     <= LW'(bit_len(32'(cv)));
          og       <= cv;
          k        <= '0;
          fv       <= cv;
          fidx     <= FIW'(FN - 1);
          fword    <= '0;
          ftop_set <= 1'b0;
        end
        ST_OM_BUILD: begin
          if (og > VW'(1)) begin
            grp[k[GIW-1:0]] <= og;
            k  <= k + 1'b1;
            og <= VW'(bit_len(32'(og))) - 1'b1;
          end
        end
        ST_OM_EMIT: begin
          if (seg_free && k != '0) k <= k_dec;
        end
        ST_F_CALC: begin
          if (fv >= fib_tab[fidx]) begin
            fword[fidx] <= 1'b1;
            fv          <= fv - fib_tab[fidx];
            if (!ftop_set) begin
              ftop     <= fidx;
              ftop_set <= 1'b1;
            end
          end
          if (fidx != '0) fidx <= fidx - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Segment shifter: MSB-first values, or LSB-first Fibonacci digits
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= '0;
    end else if (seg_load) begin
      seg_len <= ld_len;
      seg_lsb <= ld_lsb;
      seg_val <= ld_lsb ? ld_val : (ld_val << (SLW'(SW) - ld_len));
    end else if (bit_fire) begin
      seg_len <= seg_len - 1'b1;
      seg_val <= seg_lsb ? (seg_val >> 1) : (seg_val << 1);
    end
  end

  // Byte packing, hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (bit_fire) begin
        if (cnt == 3'd7) begin
          if (hold_valid) begin
            packed_byte <= hold_byte;
            run_last    <= 1'b0;
            stream_done <= hold_done;
          end
          hold_byte  <= {acc, bit_val};
          hold_done  <= 1'b0;
          hold_valid <= 1'b1;
          acc        <= '0;
          cnt        <= '0;
        end else begin
          acc <= {acc[5:0], bit_val};
          cnt <= cnt + 1'b1;
        end
      end else if (state == ST_PAD && (!hold_valid || out_free)) begin
        if (hold_valid) begin
          packed_byte <= hold_byte;
          run_last    <= 1'b0;
          stream_done <= hold_done;
        end
        hold_byte  <= pad_byte;
        hold_done  <= 1'b1;
        hold_valid <= 1'b1;
        acc        <= '0;
        cnt        <= '0;
      end else if (state == ST_FLUSH && hold_valid && out_free) begin
        packed_byte <= hold_byte;
        run_last    <= 1'b1;
        stream_done <= hold_done;
        hold_valid  <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Between items no byte is held back and no code bits are in flight
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_valid && seg_len == '0)
    else $error("idle with pending output");

  // First byte of a stream without end produces nothing and frees the input
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !phrase_open && !stream_end |=> in_ready && phrase_open)
    else $error("first byte did not return to idle");

  // Padding resets the dictionary fill count
  a_pad_reset: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD && state_next == ST_FLUSH |=> next_code == (CW+1)'(ALPHABET))
    else $error("fill count not reset after padding");

  // Fibonacci digits always have a top digit before emission
  a_fib_top: assert property (@(posedge clk) disable iff (rst)
    state == ST_F_EMIT |-> ftop_set)
    else $error("Fibonacci top digit missing");
`endif

endmodule

`default_nettype wire
